/* hw/rtl/hvt_pkg.sv */
package hvt_pkg;

   // Default number of fraction bits of the fixed-point format.
   localparam int HVT_FRAC_BITS = 16;

   // Request opcodes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_XFORM = 1'b1;

   // Saturation limits of a 32-bit result.
   localparam logic signed [31:0] HVT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] HVT_MIN = 32'sh8000_0000;

   // Bit set on each diagonal entry (row equals column) of the matrix.
   localparam logic [15:0] HVT_DIAG_MASK = 16'h8421;

   typedef struct packed {
      logic               opcode;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               w_was_zero;
      logic               saturated;
   } rsp_data_type;

   // Start of one division, from the sequencer to the divider.
   typedef struct packed {
      logic               start;
      logic signed [31:0] numer;
      logic signed [31:0] denom;
   } div_req_type;

   // Completion of one division, from the divider to the sequencer.
   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
      logic               saturated;
   } div_rsp_type;

endpackage

/* hw/rtl/hvt_divider.sv */
module hvt_divider #(
   parameter int FRAC_BITS = hvt_pkg::HVT_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hvt_pkg::div_req_type div_req,
   output hvt_pkg::div_rsp_type div_rsp
);
   import hvt_pkg::*;

   // The dividend is |numer| shifted left by FRAC_BITS. Only the low 33
   // quotient bits are developed; anything above them is an overflow.
   localparam int DW = 32 + FRAC_BITS;
   localparam int QW = 33;

   logic [31:0]   rem_ff, rem_in;
   logic [QW-1:0] dvd_ff, dvd_in;
   logic [31:0]   dsr_ff, dsr_in;
   logic          neg_ff, neg_in;
   logic          ovf_ff, ovf_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;

   logic [31:0]   mag_n;
   logic [31:0]   mag_d;
   logic [DW-1:0] dividend;
   logic [31:0]   dividend_hi;
   logic [33:0]   trial;
   logic          trial_ge;
   logic          big_pos;
   logic          big_neg;
   logic          quot_sat;
   logic [31:0]   quot_neg;

   // Magnitudes of the operands and the upper dividend bits that seed the
   // remainder.
   always_comb begin
      mag_n       = div_req.numer[31] ? 32'(-div_req.numer) : div_req.numer;
      mag_d       = div_req.denom[31] ? 32'(-div_req.denom) : div_req.denom;
      dividend    = {mag_n, {FRAC_BITS{1'b0}}};
      dividend_hi = 32'(dividend[DW-1:QW]);
   end

   // One restoring subtract step per cycle.
   always_comb begin
      trial    = {1'b0, rem_ff, dvd_ff[QW-1]} - {2'b00, dsr_ff};
      trial_ge = !trial[33];
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = dividend_hi;
         dvd_in  = dividend[QW-1:0];
         dsr_in  = mag_d;
         neg_in  = div_req.numer[31] ^ div_req.denom[31];
         ovf_in  = dividend_hi >= mag_d;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial[31:0] : {rem_ff[30:0], dvd_ff[QW-1]};
         dvd_in = {dvd_ff[QW-2:0], trial_ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   // Sign the magnitude and clamp it to the 32-bit range.
   always_comb begin
      big_pos  = dvd_ff[32] | dvd_ff[31];
      big_neg  = dvd_ff[32] | (dvd_ff[31] & (|dvd_ff[30:0]));
      quot_sat = ovf_ff | (neg_ff ? big_neg : big_pos);
      quot_neg = 32'(-dvd_ff);
      div_rsp.done      = done_ff;
      div_rsp.saturated = quot_sat;
      if (quot_sat) begin
         div_rsp.quotient = neg_ff ? HVT_MIN : HVT_MAX;
      end else begin
         div_rsp.quotient = neg_ff ? quot_neg : dvd_ff[31:0];
      end
   end

endmodule

/* hw/rtl/homogeneous_vertex_transform.sv */
// Homogeneous vertex transform: a 4x4 matrix of signed fixed-point entries
// (FRAC_BITS fraction bits, identity after reset) is loaded one entry per
// load request, which gives no response and leaves the block ready. A
// transform request multiplies (x, y, z, 1) by the matrix through one shared
// 32x32 multiplier and accumulator, each entry taking a multiply step and
// then an accumulate step, and then divides x, y and z by w in one shared
// radix-2 divider, one after another. When w comes out zero the divisions
// are skipped. The block accepts no request while a transform is in
// progress. A finished response waits in an output register, so the next
// request is accepted while it is still pending.
module homogeneous_vertex_transform #(
   parameter int FRAC_BITS = hvt_pkg::HVT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hvt_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hvt_pkg::rsp_data_type rsp_data
);
   import hvt_pkg::*;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_MUL       = 6'b000010,
      ST_ACC       = 6'b000100,
      ST_DIV_START = 6'b001000,
      ST_DIV_WAIT  = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] mat_ff [16];
   logic signed [31:0] mat_in [16];
   logic signed [31:0] res_ff [4];
   logic signed [31:0] res_in [4];
   logic signed [31:0] px_ff, px_in;
   logic signed [31:0] py_ff, py_in;
   logic signed [31:0] pz_ff, pz_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [3:0]         idx_ff, idx_in;
   logic [1:0]         row_ff, row_in;
   logic               sat_ff, sat_in;
   logic               wzero_ff, wzero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] acc_sum;
   logic               clamp_hi;
   logic               clamp_lo;
   logic signed [31:0] clamped;
   logic               out_free;
   logic               req_fire;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   hvt_divider #(
      .FRAC_BITS(FRAC_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Multiplier operands: the current matrix entry and the matching point
   // component, with w fixed at one.
   always_comb begin
      mul_a = mat_ff[idx_ff];
      unique case (idx_ff[1:0])
         2'd0:    mul_b = px_ff;
         2'd1:    mul_b = py_ff;
         2'd2:    mul_b = pz_ff;
         default: mul_b = ONE;
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // Floor-shifted product into the row sum, and the row sum clamp.
   always_comb begin
      acc_sum  = acc_ff + (prod_ff >>> FRAC_BITS);
      clamp_hi = !acc_sum[63] && (|acc_sum[62:31]);
      clamp_lo = acc_sum[63] && !(&acc_sum[62:31]);
      if (clamp_hi) begin
         clamped = HVT_MAX;
      end else if (clamp_lo) begin
         clamped = HVT_MIN;
      end else begin
         clamped = acc_sum[31:0];
      end
   end

   // Divider operands come from the stored row results.
   always_comb begin
      div_req.start = (state_ff == ST_DIV_START);
      div_req.numer = res_ff[row_ff];
      div_req.denom = res_ff[3];
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      mat_in       = mat_ff;
      res_in       = res_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      sat_in       = sat_ff;
      wzero_in     = wzero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == OP_LOAD) begin
                  mat_in[req_data.entry_index] = req_data.entry_value;
               end else begin
                  px_in    = req_data.in_x;
                  py_in    = req_data.in_y;
                  pz_in    = req_data.in_z;
                  acc_in   = '0;
                  idx_in   = '0;
                  sat_in   = 1'b0;
                  wzero_in = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_sum;
            state_in = ST_MUL;
            idx_in   = idx_ff + 4'd1;
            // Last column of a row: clamp and store the component.
            if (idx_ff[1:0] == 2'd3) begin
               res_in[idx_ff[3:2]] = clamped;
               acc_in              = '0;
               sat_in              = sat_ff | clamp_hi | clamp_lo;
               if (idx_ff[3:2] == 2'd3) begin
                  row_in = 2'd0;
                  if (clamped == 32'sd0) begin
                     wzero_in = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_DIV_START;
                  end
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               res_in[row_ff] = div_rsp.quotient;
               sat_in         = sat_ff | div_rsp.saturated;
               if (row_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_FINISH: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_data_in.out_x      = res_ff[0];
               rsp_data_in.out_y      = res_ff[1];
               rsp_data_in.out_z      = res_ff[2];
               rsp_data_in.w_was_zero = wzero_ff;
               rsp_data_in.saturated  = sat_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= HVT_DIAG_MASK[i] ? ONE : 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff       <= mat_in;
      end
      res_ff      <= res_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      sat_ff      <= sat_in;
      wzero_ff    <= wzero_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
